[rtl/core/gdh_pkg.sv]
// Shared constants and request/result types for the gradient difference hash.
`default_nettype none
package gdh_pkg;

    localparam int GRID_SIZE  = 8;
    localparam int PIXEL_BITS = 8;

    localparam int PIX_FIELD_W = 8;
    localparam int HALF_W      = 56;

    // pixel bits that take part in comparisons
    localparam int PIX_W  = (PIXEL_BITS < PIX_FIELD_W) ? PIXEL_BITS : PIX_FIELD_W;
    localparam int CNT_W  = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
    localparam int HASH_W = GRID_SIZE * (GRID_SIZE - 1);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GRID_SIZE - 1);

    localparam logic HALF_HORIZ = 1'b0;
    localparam logic HALF_VERT  = 1'b1;

    typedef struct packed {
        logic [PIX_FIELD_W-1:0] pixel;
        logic                   start_of_frame;
    } t_pix_req;

    typedef struct packed {
        logic [HALF_W-1:0] hash_half;
        logic              half_select;
        logic              last;
    } t_hash_res;

endpackage
`default_nettype wire

[rtl/core/gdh_cell.sv]
// One line-buffer cell: holds a pixel and passes it to its neighbor on each request.
`default_nettype none
module gdh_cell
    import gdh_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [PIX_W-1:0] i_pix,
    output logic      [PIX_W-1:0] o_pix
);

    logic [PIX_W-1:0] r_pix;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix <= i_pix;
        end
    end

    assign o_pix = r_pix;

endmodule
`default_nettype wire

[rtl/core/gradient_difference_hash_top.sv]
// Top level of the gradient difference hash: cell chain, counters and result stage.
//
// Input channel (i_valid / o_stall / i_req) takes one gray pixel per request in
// raster order; start_of_frame restarts the image at position (0, 0).
// Output channel (o_valid / i_stall / o_res) gives two results per image: the
// horizontal half, then the vertical half with last set.
// Throughput is one pixel per cycle while o_stall is low. A row of GRID_SIZE cells acts as the line
// buffer: the left neighbor sits in the first cell, the pixel above in the last.
// Gradient bits shift into two registers in raster order of their comparisons.
// The horizontal half appears in the cycle after the last pixel is taken,
// the vertical half in the cycle after the horizontal half is taken.
// The result stage holds both halves; only the final pixel of an image is held
// off (o_stall) while a previous image's results are still waiting, so a
// stalled receiver costs at most that one pixel's wait.
// Reset (i_rst_n low, synchronous) clears counters and result valids; the
// next pixel starts a new image.
`default_nettype none
module gradient_difference_hash_top
    import gdh_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_pix_req  i_req,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_hash_res      o_res
);

    logic [CNT_W-1:0]  r_col, n_col;
    logic [CNT_W-1:0]  r_row, n_row;
    logic [HASH_W-1:0] r_hbits, n_hbits;
    logic [HASH_W-1:0] r_vbits, n_vbits;
    logic              r_out_valid;
    t_hash_res         r_out;
    logic              r_pend_valid;
    logic [HALF_W-1:0] r_pend;

    logic              in_take;
    logic              out_take;
    logic              at_end;
    logic              done;
    logic [CNT_W-1:0]  col_eff;
    logic [CNT_W-1:0]  row_eff;
    logic [PIX_W-1:0]  pix;
    logic [PIX_W-1:0]  chain [GRID_SIZE+1];
    logic              hbit;
    logic              vbit;

    assign pix      = i_req.pixel[PIX_W-1:0];
    assign at_end   = (r_col == CNT_LAST) && (r_row == CNT_LAST);
    assign o_stall  = at_end && (r_out_valid || r_pend_valid);
    assign in_take  = i_valid && !o_stall;
    assign out_take = r_out_valid && !i_stall;

    // line buffer: chain[1] is the left neighbor, chain[GRID_SIZE] the pixel above
    assign chain[0] = pix;
    for (genvar g = 0; g < GRID_SIZE; g++) begin : g_cell
        gdh_cell u_cell (
            .i_clk (i_clk),
            .i_en  (in_take),
            .i_pix (chain[g]),
            .o_pix (chain[g+1])
        );
    end

    always_comb begin
        col_eff = i_req.start_of_frame ? '0 : r_col;
        row_eff = i_req.start_of_frame ? '0 : r_row;
        hbit    = chain[1] < pix;
        vbit    = chain[GRID_SIZE] < pix;
        n_hbits = {hbit, r_hbits[HASH_W-1:1]};
        n_vbits = {vbit, r_vbits[HASH_W-1:1]};
        done    = (col_eff == CNT_LAST) && (row_eff == CNT_LAST);
        if (col_eff == CNT_LAST) begin
            n_col = '0;
            n_row = (row_eff == CNT_LAST) ? '0 : row_eff + 1'b1;
        end else begin
            n_col = col_eff + 1'b1;
            n_row = row_eff;
        end
    end

    // bit registers need no clear: an image shifts in exactly HASH_W bits of each
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            if (col_eff != '0) begin
                r_hbits <= n_hbits;
            end
            if (row_eff != '0) begin
                r_vbits <= n_vbits;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (in_take && done) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid  <= r_pend_valid;
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && done) begin
            r_out.hash_half   <= HALF_W'((col_eff != '0) ? n_hbits : r_hbits);
            r_out.half_select <= HALF_HORIZ;
            r_out.last        <= 1'b0;
            r_pend            <= HALF_W'((row_eff != '0) ? n_vbits : r_vbits);
        end else if (out_take && r_pend_valid) begin
            r_out.hash_half   <= r_pend;
            r_out.half_select <= HALF_VERT;
            r_out.last        <= 1'b1;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule
`default_nettype wire

[verif/tb_gradient_difference_hash_top.sv]
// Self-checking testbench for gradient_difference_hash_top: pixel stimulus and hash checks.
module tb_gradient_difference_hash_top
    import gdh_pkg::*;
();

    localparam int RUN_LIMIT    = 800000;   // time units, far above the slowest run
    localparam int HOLD_LEN     = 300;      // receiver hold-off, cycles
    localparam int PHASE_PIXELS = 260;
    localparam int IMG_PIXELS   = GRID_SIZE * GRID_SIZE;

    typedef enum int {IMG_FULL, IMG_CUT, IMG_NOISE} t_img_kind;
    typedef enum int {
        FILL_RANDOM, FILL_NARROW, FILL_EXTREME, FILL_RAMP_UP, FILL_RAMP_DOWN, FILL_FLAT
    } t_fill;

    // Predicts both hash halves from the accepted pixel stream and checks results.
    class dhash_checker;
        logic [PIX_W-1:0]  prev_pix;
        logic [PIX_W-1:0]  line_buf [GRID_SIZE];
        int                col;
        int                row;
        logic [HALF_W-1:0] horiz_bits;
        logic [HALF_W-1:0] vert_bits;
        t_hash_res         halves_due [$];
        int                mismatches;
        int                pixels_seen;
        int                halves_checked;
        int                restarts;

        function new();
            prev_pix = '0;
            foreach (line_buf[k]) line_buf[k] = '0;
            col = 0;
            row = 0;
            horiz_bits = '0;
            vert_bits = '0;
            mismatches = 0;
            pixels_seen = 0;
            halves_checked = 0;
            restarts = 0;
        endfunction

        task flag_mismatch(input string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        function void take_pixel(input t_pix_req req);
            logic [PIX_W-1:0] p;
            p = req.pixel[PIX_W-1:0];
            pixels_seen++;
            if (req.start_of_frame) begin
                if (col != 0 || row != 0)
                    restarts++;
                col = 0;
                row = 0;
                horiz_bits = '0;
                vert_bits = '0;
            end
            if (col != 0 && prev_pix < p)
                horiz_bits[row * (GRID_SIZE - 1) + col - 1] = 1'b1;
            if (row != 0 && line_buf[col] < p)
                vert_bits[(row - 1) * GRID_SIZE + col] = 1'b1;
            line_buf[col] = p;
            prev_pix = p;
            if (col == GRID_SIZE - 1) begin
                col = 0;
                if (row == GRID_SIZE - 1) begin
                    halves_due.push_back('{hash_half: horiz_bits, half_select: HALF_HORIZ,
                                           last: 1'b0});
                    halves_due.push_back('{hash_half: vert_bits, half_select: HALF_VERT,
                                           last: 1'b1});
                    row = 0;
                    horiz_bits = '0;
                    vert_bits = '0;
                end else begin
                    row++;
                end
            end else begin
                col++;
            end
        endfunction

        task check_half(input t_hash_res got);
            t_hash_res want;
            if (halves_due.size() == 0) begin
                flag_mismatch($sformatf("result %h with none expected", got));
                return;
            end
            want = halves_due.pop_front();
            halves_checked++;
            if (got.hash_half !== want.hash_half)
                flag_mismatch($sformatf("hash_half %h, expected %h",
                                        got.hash_half, want.hash_half));
            if (got.half_select !== want.half_select)
                flag_mismatch($sformatf("half_select %b, expected %b",
                                        got.half_select, want.half_select));
            if (got.last !== want.last)
                flag_mismatch($sformatf("last %b, expected %b", got.last, want.last));
        endtask
    endclass

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_stall = 1'b0;
    t_pix_req  i_req   = '0;
    logic      o_stall;
    logic      o_valid;
    t_hash_res o_res;

    dhash_checker hash_board = new();

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int pixels_sent  = 0;
    bit hold_trig    = 1'b0;
    bit hold_seen    = 1'b0;
    int hold_left    = 0;

    gradient_difference_hash_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                hash_board.check_half(o_res);
            if (i_valid && !o_stall)
                hash_board.take_pixel(i_req);
        end
    end

    // receiver: random stalls, plus a long hold-off started by toggling hold_trig
    always @(posedge i_clk) begin
        if (hold_trig != hold_seen) begin
            hold_seen <= hold_trig;
            hold_left <= HOLD_LEN;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    task automatic send_pixel(input logic [7:0] pix, input logic sof);
        t_pix_req req;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        req.pixel = pix;
        req.start_of_frame = sof;
        i_valid <= 1'b1;
        i_req   <= req;
        do @(posedge i_clk); while (o_stall);
        pixels_sent++;
    endtask

    function automatic logic [7:0] fill_pixel(input t_fill fill, input int idx,
                                              input logic [7:0] base);
        case (fill)
            FILL_NARROW:    return base + 8'($urandom_range(3));
            FILL_EXTREME:   return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            FILL_RAMP_UP:   return 8'(idx * 4);
            FILL_RAMP_DOWN: return 8'(255 - idx * 4);
            FILL_FLAT:      return base;
            default:        return 8'($urandom);
        endcase
    endfunction

    task automatic send_image(input t_img_kind kind);
        t_fill      fill;
        int         len;
        logic [7:0] base;
        logic       sof;
        fill = ($urandom_range(1) != 0) ? FILL_RANDOM
                                        : t_fill'($urandom_range(FILL_FLAT, FILL_NARROW));
        base = 8'($urandom_range(255));
        case (kind)
            IMG_FULL: len = IMG_PIXELS;
            IMG_CUT:  len = $urandom_range(IMG_PIXELS - 1, 1);
            default:  len = $urandom_range(20, 1);
        endcase
        for (int i = 0; i < len; i++) begin
            // most images open with the start flag; some rely on counter wrap
            if (kind == IMG_NOISE)
                sof = ($urandom_range(1) != 0);
            else
                sof = (i == 0) && ($urandom_range(3) != 0);
            send_pixel(fill_pixel(fill, i, base), sof);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int first;
        int pick;
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        first = pixels_sent;
        while (pixels_sent - first < PHASE_PIXELS) begin
            pick = $urandom_range(99);
            if (pick < 80)
                send_image(IMG_FULL);
            else if (pick < 92)
                send_image(IMG_CUT);
            else
                send_image(IMG_NOISE);
        end
    endtask

    // sender goes quiet until every pending hash half has been taken
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (hash_board.halves_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_directed();
        // {start_of_frame, pixel}: first row without start flag, extremes, ties,
        // then restarts mid-row, two of them back to back
        bit [8:0] seq [$] = '{
            9'h0FF, 9'h000, 9'h0FF, 9'h0FF, 9'h0FE, 9'h0FF, 9'h001, 9'h000,
            9'h000, 9'h001, 9'h080, 9'h107, 9'h107, 9'h008, 9'h0FF, 9'h100,
            9'h0FF, 9'h080, 9'h081, 9'h07F
        };
        foreach (seq[k])
            send_pixel(seq[k][7:0], seq[k][8]);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_phase(0, 0);
        run_phase(52, 0);

        // long receiver hold-off while images keep coming, so the input stalls
        drain();
        hold_trig    <= ~hold_trig;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        repeat (3) begin
            send_pixel(8'($urandom), 1'b1);
            for (int i = 1; i < IMG_PIXELS; i++)
                send_pixel(8'($urandom), 1'b0);
        end

        run_phase(0, 52);
        drain();
        run_phase(36, 36);

        rx_stall_pct = 0;
        drain();
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d pixels over four idling phases and a %0d-cycle hold-off,",
                 hash_board.pixels_seen, HOLD_LEN);
        $display("with %0d restarts mid-image; %0d hash halves checked, %0d mismatches.",
                 hash_board.restarts, hash_board.halves_checked, hash_board.mismatches);
        if (hash_board.mismatches == 0 && hash_board.halves_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #RUN_LIMIT;
        $display("timeout after %0d time units", RUN_LIMIT);
        $display("FAIL");
        $finish;
    end

endmodule
